// ----- src/sbf_pkg.sv -----
package sbf_pkg;

  localparam int unsigned SBF_CELLS = 19;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_READ   = 2'd1;
  localparam logic [1:0] OP_ACTION = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [7:0] HDR_BYTE     = 8'hff;
  localparam logic [7:0] WRITE_LEN    = 8'd15;
  localparam logic [7:0] READ_LEN     = 8'd4;
  localparam logic [7:0] ACTION_LEN   = 8'd2;
  localparam logic [7:0] INSTR_READ   = 8'd2;
  localparam logic [7:0] INSTR_WRITE  = 8'd4;
  localparam logic [7:0] INSTR_ACTION = 8'd5;
  localparam logic [7:0] WRITE_ADDR   = 8'd24;
  localparam logic [7:0] READ_ADDR    = 8'd36;
  localparam logic [7:0] READ_COUNT   = 8'd6;
  localparam logic [7:0] BROADCAST_ID = 8'd254;

  typedef enum logic [1:0] {
    KIND_HDR  = 2'd0,
    KIND_DATA = 2'd1,
    KIND_CHK  = 2'd2
  } kind_t;

  typedef struct packed {
    logic       valid;
    kind_t      kind;
    logic [7:0] data;
  } cell_t;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] servo_id;
    logic       torque_enable;
    logic       led_on;
    logic [7:0] cw_margin;
    logic [7:0] ccw_margin;
    logic [7:0] cw_slope;
    logic [7:0] ccw_slope;
    logic [9:0] goal_position;
    logic [9:0] moving_speed;
    logic [9:0] torque_limit;
  } cmd_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_byte;
  } tx_t;

endpackage

// ----- src/sbf_cell.sv -----
module sbf_cell (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  logic          shift,
  input  sbf_pkg::cell_t load_cell,
  input  sbf_pkg::cell_t neighbour,
  output sbf_pkg::cell_t slot
);

  sbf_pkg::cell_t slot_next;

  always_comb begin
    if (load) begin
      slot_next = load_cell;
    end else if (shift) begin
      slot_next = neighbour;
    end else begin
      slot_next = slot;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot.valid <= 1'b0;
    end else begin
      slot.valid <= slot_next.valid;
    end
    slot.kind <= slot_next.kind;
    slot.data <= slot_next.data;
  end

endmodule

// ----- src/sbf_emit.sv -----
module sbf_emit (
  input  logic           clk,
  input  logic           rst,
  input  sbf_pkg::cell_t head,
  input  logic           stall,
  output logic           shift,
  output logic           valid,
  output sbf_pkg::tx_t   tx
);

  logic [7:0] sum;

  assign shift = head.valid && (!valid || !stall);

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (shift) begin
      valid <= 1'b1;
    end else if (!stall) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (shift) begin
      case (head.kind)
        sbf_pkg::KIND_HDR: begin
          sum          <= 8'd0;
          tx.out_byte  <= head.data;
          tx.last_byte <= 1'b0;
        end
        sbf_pkg::KIND_DATA: begin
          sum          <= sum + head.data;
          tx.out_byte  <= head.data;
          tx.last_byte <= 1'b0;
        end
        sbf_pkg::KIND_CHK: begin
          tx.out_byte  <= ~sum;
          tx.last_byte <= 1'b1;
        end
        default: begin
          tx.out_byte  <= head.data;
          tx.last_byte <= 1'b0;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_chk_marks_last: assert property (@(posedge clk) disable iff (rst)
    shift && head.kind == sbf_pkg::KIND_CHK |=> valid && tx.last_byte)
    else $error("checksum word not marked last");
  a_hdr_not_last: assert property (@(posedge clk) disable iff (rst)
    shift && head.kind == sbf_pkg::KIND_HDR |=> valid && !tx.last_byte
      && tx.out_byte == sbf_pkg::HDR_BYTE)
    else $error("header word corrupted");
  a_chk_value: assert property (@(posedge clk) disable iff (rst)
    shift && head.kind == sbf_pkg::KIND_CHK |=> tx.out_byte == ~$past(sum))
    else $error("checksum word mismatch");
`endif

endmodule

// ----- src/servo_bus_instruction_packet_framer.sv -----
// Servo bus instruction packet framer. Each command word becomes one instruction
// packet, sent one byte per word on the tx channel, with last_byte set on the
// closing checksum byte. A register write gives 19 bytes, a read request 8 and an
// action 6; an unused operation code is taken and gives nothing. The packet is
// loaded into a row of 19 byte cells that shifts one place toward the output
// register each cycle tx is not stalled, and the checksum is summed as the bytes
// leave. The next command is taken in the cycle the previous packet's last byte
// leaves the row, so packets follow with no gap; an unused operation code is
// taken on an empty row and loads no bytes into it.
module servo_bus_instruction_packet_framer (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_stall,
  input  sbf_pkg::cmd_t cmd,
  output logic          tx_valid,
  input  logic          tx_stall,
  output sbf_pkg::tx_t  tx
);

  sbf_pkg::cell_t chain [sbf_pkg::SBF_CELLS];
  sbf_pkg::cell_t image [sbf_pkg::SBF_CELLS];
  logic [sbf_pkg::SBF_CELLS-1:0] occupied;
  logic shift;
  logic load;
  logic empty_next;

  function automatic sbf_pkg::cell_t mk(sbf_pkg::kind_t kind, logic [7:0] data);
    sbf_pkg::cell_t c;
    c.valid = 1'b1;
    c.kind  = kind;
    c.data  = data;
    return c;
  endfunction

  always_comb begin
    for (int i = 0; i < sbf_pkg::SBF_CELLS; i++) begin
      image[i] = '0;
    end
    case (cmd.operation)
      sbf_pkg::OP_WRITE: begin
        image[0]  = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[1]  = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[2]  = mk(sbf_pkg::KIND_DATA, cmd.servo_id);
        image[3]  = mk(sbf_pkg::KIND_DATA, sbf_pkg::WRITE_LEN);
        image[4]  = mk(sbf_pkg::KIND_DATA, sbf_pkg::INSTR_WRITE);
        image[5]  = mk(sbf_pkg::KIND_DATA, sbf_pkg::WRITE_ADDR);
        image[6]  = mk(sbf_pkg::KIND_DATA, {7'd0, cmd.torque_enable});
        image[7]  = mk(sbf_pkg::KIND_DATA, {7'd0, cmd.led_on});
        image[8]  = mk(sbf_pkg::KIND_DATA, cmd.cw_margin);
        image[9]  = mk(sbf_pkg::KIND_DATA, cmd.ccw_margin);
        image[10] = mk(sbf_pkg::KIND_DATA, cmd.cw_slope);
        image[11] = mk(sbf_pkg::KIND_DATA, cmd.ccw_slope);
        image[12] = mk(sbf_pkg::KIND_DATA, cmd.goal_position[7:0]);
        image[13] = mk(sbf_pkg::KIND_DATA, {6'd0, cmd.goal_position[9:8]});
        image[14] = mk(sbf_pkg::KIND_DATA, cmd.moving_speed[7:0]);
        image[15] = mk(sbf_pkg::KIND_DATA, {6'd0, cmd.moving_speed[9:8]});
        image[16] = mk(sbf_pkg::KIND_DATA, cmd.torque_limit[7:0]);
        image[17] = mk(sbf_pkg::KIND_DATA, {6'd0, cmd.torque_limit[9:8]});
        image[18] = mk(sbf_pkg::KIND_CHK, 8'd0);
      end
      sbf_pkg::OP_READ: begin
        image[0] = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[1] = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[2] = mk(sbf_pkg::KIND_DATA, cmd.servo_id);
        image[3] = mk(sbf_pkg::KIND_DATA, sbf_pkg::READ_LEN);
        image[4] = mk(sbf_pkg::KIND_DATA, sbf_pkg::INSTR_READ);
        image[5] = mk(sbf_pkg::KIND_DATA, sbf_pkg::READ_ADDR);
        image[6] = mk(sbf_pkg::KIND_DATA, sbf_pkg::READ_COUNT);
        image[7] = mk(sbf_pkg::KIND_CHK, 8'd0);
      end
      sbf_pkg::OP_ACTION: begin
        image[0] = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[1] = mk(sbf_pkg::KIND_HDR, sbf_pkg::HDR_BYTE);
        image[2] = mk(sbf_pkg::KIND_DATA, sbf_pkg::BROADCAST_ID);
        image[3] = mk(sbf_pkg::KIND_DATA, sbf_pkg::ACTION_LEN);
        image[4] = mk(sbf_pkg::KIND_DATA, sbf_pkg::INSTR_ACTION);
        image[5] = mk(sbf_pkg::KIND_CHK, 8'd0);
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < sbf_pkg::SBF_CELLS; i++) begin
      occupied[i] = chain[i].valid;
    end
  end

  assign empty_next = shift ? ~|occupied[sbf_pkg::SBF_CELLS-1:1] : ~|occupied;
  assign cmd_stall  = !empty_next;
  assign load       = cmd_valid && !cmd_stall;

  for (genvar g = 0; g < sbf_pkg::SBF_CELLS; g++) begin : g_cell
    sbf_pkg::cell_t neighbour;
    if (g == sbf_pkg::SBF_CELLS - 1) begin : g_tail
      assign neighbour = '0;
    end else begin : g_mid
      assign neighbour = chain[g+1];
    end
    sbf_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .load      (load),
      .shift     (shift),
      .load_cell (image[g]),
      .neighbour (neighbour),
      .slot      (chain[g])
    );
  end

  sbf_emit u_emit (
    .clk   (clk),
    .rst   (rst),
    .head  (chain[0]),
    .stall (tx_stall),
    .shift (shift),
    .valid (tx_valid),
    .tx    (tx)
  );

`ifndef SYNTHESIS
  a_load_starts_hdr: assert property (@(posedge clk) disable iff (rst)
    load && cmd.operation != sbf_pkg::OP_UNUSED
      |=> chain[0].valid && chain[0].kind == sbf_pkg::KIND_HDR)
    else $error("packet did not start with header");
  a_unused_op_empty: assert property (@(posedge clk) disable iff (rst)
    load && cmd.operation == sbf_pkg::OP_UNUSED |=> !chain[0].valid)
    else $error("unused operation produced words");
  a_row_packed: assert property (@(posedge clk) disable iff (rst)
    !chain[0].valid |-> !chain[1].valid)
    else $error("gap at head of cell row");
`endif

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int IDLE_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 40;
  localparam int MAX_REPORTS = 10;

  logic clk;
  logic rst = 1'b1;
  logic cmd_valid = 1'b0;
  logic cmd_stall;
  sbf_pkg::cmd_t cmd = '0;
  logic tx_valid;
  logic tx_stall = 1'b0;
  sbf_pkg::tx_t tx;

  sbf_pkg::tx_t expected_bytes[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int sender_idle_pct = 0;
  int rx_stall_pct = 0;

  servo_bus_instruction_packet_framer dut (
    .clk(clk),
    .rst(rst),
    .cmd_valid(cmd_valid),
    .cmd_stall(cmd_stall),
    .cmd(cmd),
    .tx_valid(tx_valid),
    .tx_stall(tx_stall),
    .tx(tx)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void frame_packet(sbf_pkg::cmd_t c);
    logic [7:0] body[$];
    logic [7:0] sum;
    case (c.operation)
      sbf_pkg::OP_WRITE: begin
        body = '{c.servo_id, sbf_pkg::WRITE_LEN, sbf_pkg::INSTR_WRITE,
                 sbf_pkg::WRITE_ADDR,
                 8'(c.torque_enable), 8'(c.led_on),
                 c.cw_margin, c.ccw_margin, c.cw_slope, c.ccw_slope,
                 c.goal_position[7:0], 8'(c.goal_position[9:8]),
                 c.moving_speed[7:0], 8'(c.moving_speed[9:8]),
                 c.torque_limit[7:0], 8'(c.torque_limit[9:8])};
      end
      sbf_pkg::OP_READ: begin
        body = '{c.servo_id, sbf_pkg::READ_LEN, sbf_pkg::INSTR_READ,
                 sbf_pkg::READ_ADDR, sbf_pkg::READ_COUNT};
      end
      sbf_pkg::OP_ACTION: begin
        body = '{sbf_pkg::BROADCAST_ID, sbf_pkg::ACTION_LEN, sbf_pkg::INSTR_ACTION};
      end
      default: begin
        return;
      end
    endcase
    sum = '0;
    foreach (body[i]) sum += body[i];
    expected_bytes.push_back(sbf_pkg::tx_t'{sbf_pkg::HDR_BYTE, 1'b0});
    expected_bytes.push_back(sbf_pkg::tx_t'{sbf_pkg::HDR_BYTE, 1'b0});
    foreach (body[i]) expected_bytes.push_back(sbf_pkg::tx_t'{body[i], 1'b0});
    expected_bytes.push_back(sbf_pkg::tx_t'{~sum, 1'b1});
  endfunction

  function automatic sbf_pkg::cmd_t random_cmd();
    sbf_pkg::cmd_t c;
    c.operation = ($urandom_range(99) < 5) ? sbf_pkg::OP_UNUSED : 2'($urandom_range(2));
    c.servo_id = 8'($urandom);
    c.torque_enable = 1'($urandom);
    c.led_on = 1'($urandom);
    c.cw_margin = 8'($urandom);
    c.ccw_margin = 8'($urandom);
    c.cw_slope = 8'($urandom);
    c.ccw_slope = 8'($urandom);
    c.goal_position = ($urandom_range(9) == 0) ? 10'h3ff : 10'($urandom);
    c.moving_speed = ($urandom_range(9) == 0) ? 10'h3ff : 10'($urandom);
    c.torque_limit = ($urandom_range(9) == 0) ? 10'h3ff : 10'($urandom);
    return c;
  endfunction

  task automatic send_cmd(input sbf_pkg::cmd_t c);
    while ($urandom_range(99) < sender_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd <= c;
    cmd_valid <= 1'b1;
    do @(posedge clk); while (cmd_stall);
    frame_packet(c);
  endtask

  task automatic wait_for_drain();
    cmd_valid <= 1'b0;
    do @(posedge clk); while (expected_bytes.size() != 0);
  endtask

  task automatic note_mismatch(input string what, input sbf_pkg::tx_t want,
                               input sbf_pkg::tx_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("mismatch (%s): expected byte %02h last %0d, got byte %02h last %0d",
               what, want.out_byte, want.last_byte, got.out_byte, got.last_byte);
    end
  endtask

  task automatic test_write_extremes();
    sbf_pkg::cmd_t c;
    c = '0;
    c.operation = sbf_pkg::OP_WRITE;
    send_cmd(c);
    c = '1;
    c.operation = sbf_pkg::OP_WRITE;
    c.servo_id = 8'd253;
    send_cmd(c);
    c.servo_id = sbf_pkg::BROADCAST_ID;
    send_cmd(c);
    c.servo_id = 8'hff;
    send_cmd(c);
    c = '0;
    c.operation = sbf_pkg::OP_WRITE;
    c.servo_id = 8'h5a;
    c.torque_enable = 1'b1;
    c.cw_margin = 8'haa;
    c.ccw_margin = 8'h55;
    c.cw_slope = 8'h0f;
    c.ccw_slope = 8'hf0;
    c.goal_position = 10'h2aa;
    c.moving_speed = 10'h155;
    c.torque_limit = 10'h3ff;
    send_cmd(c);
    c.torque_enable = 1'b0;
    c.led_on = 1'b1;
    c.goal_position = 10'h155;
    c.moving_speed = 10'h2aa;
    c.torque_limit = 10'h100;
    send_cmd(c);
  endtask

  task automatic test_read_requests();
    sbf_pkg::cmd_t c;
    logic [7:0] ids[4];
    ids = '{8'h00, 8'd253, sbf_pkg::BROADCAST_ID, 8'hff};
    foreach (ids[i]) begin
      c = random_cmd();
      c.operation = sbf_pkg::OP_READ;
      c.servo_id = ids[i];
      send_cmd(c);
    end
  endtask

  task automatic test_action();
    sbf_pkg::cmd_t c;
    c = random_cmd();
    c.operation = sbf_pkg::OP_ACTION;
    c.servo_id = 8'h00;
    send_cmd(c);
    c = '1;
    c.operation = sbf_pkg::OP_ACTION;
    send_cmd(c);
  endtask

  task automatic test_unused_op();
    sbf_pkg::cmd_t c;
    c = '1;
    send_cmd(c);
    c = random_cmd();
    c.operation = sbf_pkg::OP_WRITE;
    send_cmd(c);
    c = '0;
    c.operation = sbf_pkg::OP_UNUSED;
    send_cmd(c);
    send_cmd(c);
    c = random_cmd();
    c.operation = sbf_pkg::OP_READ;
    send_cmd(c);
  endtask

  task automatic test_pause_until_drained();
    sbf_pkg::cmd_t c;
    sender_idle_pct = 0;
    rx_stall_pct = 50;
    repeat (3) send_cmd(random_cmd());
    wait_for_drain();
    repeat (3) begin
      c = random_cmd();
      c.operation = sbf_pkg::OP_WRITE;
      send_cmd(c);
    end
  endtask

  task automatic test_random_traffic(input int n, input int idle_pct, input int stall_pct);
    sbf_pkg::cmd_t c;
    int sent = 0;
    sender_idle_pct = idle_pct;
    rx_stall_pct = stall_pct;
    while (sent < n) begin
      c = random_cmd();
      send_cmd(c);
      if (c.operation != sbf_pkg::OP_UNUSED) sent++;
    end
  endtask

  always @(posedge clk) begin
    tx_stall <= ($urandom_range(99) < rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && tx_valid && !tx_stall) begin
      if (expected_bytes.size() == 0) begin
        note_mismatch("no packet pending", '0, tx);
      end else begin
        if (expected_bytes[0].out_byte !== tx.out_byte ||
            expected_bytes[0].last_byte !== tx.last_byte) begin
          note_mismatch("wrong field", expected_bytes[0], tx);
        end
        void'(expected_bytes.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (tx_valid && !tx_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_write_extremes();
    test_read_requests();
    test_action();
    test_unused_op();
    test_pause_until_drained();
    test_random_traffic(115, 0, 0);
    test_random_traffic(115, 84, 0);
    test_random_traffic(115, 0, 84);
    test_random_traffic(115, 7, 7);
    wait_for_drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0 && expected_bytes.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
